[rtl/zcsd_pkg.sv]
// Shared types, constants and helpers for the z-cylinder side and distance block.
// Used by the front, square root, divide and top modules and by the testbench; depends on nothing else.
`default_nettype none

package zcsd_pkg;

    // Fraction bits of positions, radius and distances.
    localparam int FRAC_BITS = 16;

    // Unit direction cosine in Q1.30.
    localparam logic signed [31:0] DIR_ONE = 32'sd1073741824;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_RADIUS   = 3'd2;
    localparam logic [2:0] CFG_SURF_ID  = 3'd3;
    localparam logic [2:0] CFG_TOL      = 3'd4;

    // Register values after reset.
    localparam logic [31:0] RST_CENTER_X = 32'd0;
    localparam logic [31:0] RST_CENTER_Y = 32'd0;
    localparam logic [30:0] RST_RADIUS   = 31'd65536;
    localparam logic [15:0] RST_SURF_ID  = 16'd0;
    localparam logic [30:0] RST_TOL      = 31'd1;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        radius;
        logic [15:0]        surface_id;
        logic [30:0]        coincident_tol;
    } zcsd_cfg_t;

    // Per-ray sideband that travels with the discriminant and the root.
    typedef struct packed {
        logic        side;
        logic        kill;
        logic        cneg;
        logic        band;
        logic        kneg;
        logic [63:0] kmag;
        logic [61:0] a;
    } zcsd_sb_t;

    // One result item.
    typedef struct packed {
        logic        no_hit;
        logic [30:0] hit_distance;
        logic        side;
    } zcsd_res_t;

    // Saturate a direction cosine to plus or minus one.
    function automatic logic signed [31:0] clamp_dir(input logic signed [31:0] d);
        logic signed [31:0] r;
        r = d;
        if (d > DIR_ONE)
        begin
            r = DIR_ONE;
        end
        else if (d < -DIR_ONE)
        begin
            r = -DIR_ONE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/zcsd_front.sv]
// Front pipeline: offsets, products, surface value c, ray term k, a and discriminant q.
// Eight register stages; depends on zcsd_pkg.
`default_nettype none

module zcsd_front
    import zcsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] dir_x,
    input  wire logic signed [31:0] dir_y,
    input  wire logic [15:0]        start_surface,
    input  wire zcsd_cfg_t          cfg,
    output logic                    out_vld,
    output logic [127:0]            q,
    output zcsd_sb_t                sb
);

    // Stage 1: offsets from the axis, magnitudes and clamped directions.
    logic signed [32:0] x_next, y_next, x_reg, y_reg;
    logic [31:0]        xmag_next, ymag_next, xmag_reg, ymag_reg;
    logic signed [31:0] ux_next, uy_next, ux_reg, uy_reg;
    logic [30:0]        uxmag_next, uymag_next, uxmag_reg, uymag_reg;
    logic               match1_reg;

    always_comb
    begin
        x_next     = {pos_x[31], pos_x} - {cfg.center_x[31], cfg.center_x};
        y_next     = {pos_y[31], pos_y} - {cfg.center_y[31], cfg.center_y};
        xmag_next  = x_next[32] ? 32'(-x_next) : x_next[31:0];
        ymag_next  = y_next[32] ? 32'(-y_next) : y_next[31:0];
        ux_next    = clamp_dir(dir_x);
        uy_next    = clamp_dir(dir_y);
        uxmag_next = ux_next[31] ? 31'(-ux_next) : ux_next[30:0];
        uymag_next = uy_next[31] ? 31'(-uy_next) : uy_next[30:0];
    end

    // Stage 2: squares and cross products, each one multiplier.
    logic [63:0]        xx_reg, yy_reg;
    logic [61:0]        rr_reg, uxx_reg, uyy_reg;
    logic signed [64:0] kx_full, ky_full;
    logic [63:0]        kx_reg, ky_reg;
    logic               match2_reg;

    always_comb
    begin
        kx_full = x_reg * ux_reg;
        ky_full = y_reg * uy_reg;
    end

    // Stage 3: c, a and k as exact sums.
    logic [65:0] c_reg;
    logic [61:0] a_reg;
    logic [63:0] k_reg;
    logic        match3_reg;

    // Stage 4: signs, magnitudes, tolerance band and side.
    logic [65:0] cmag_next, cmag_reg, tolw;
    logic [63:0] kmag_next;
    zcsd_sb_t    sb4_next, sb4_reg;

    always_comb
    begin
        tolw      = 66'(cfg.coincident_tol) << FRAC_BITS;
        cmag_next = c_reg[65] ? 66'(-c_reg) : c_reg;
        kmag_next = k_reg[63] ? 64'(-k_reg) : k_reg;
        sb4_next.cneg = c_reg[65];
        sb4_next.kneg = k_reg[63];
        sb4_next.kmag = kmag_next;
        sb4_next.a    = a_reg;
        sb4_next.band = cmag_next < tolw;
        sb4_next.kill = (a_reg == '0) || match3_reg;
        if (tolw < cmag_next)
        begin
            sb4_next.side = !c_reg[65];
        end
        else
        begin
            sb4_next.side = !k_reg[63] && (k_reg != '0);
        end
    end

    // Stage 5: partial products of a*|c| and k*k.
    logic [63:0] p00_reg, p01_reg, k00_reg, k01_reg, k11_reg;
    logic [33:0] p02_reg;
    logic [61:0] p10_reg, p11_reg;
    logic [31:0] p12_reg;
    zcsd_sb_t    sb5_reg;

    // Stage 6: partial sums.
    logic [127:0] aca_next, acb_next, k2a_next, k2b_next;
    logic [127:0] aca_reg, acb_reg, k2a_reg, k2b_reg;
    zcsd_sb_t     sb6_reg;

    always_comb
    begin
        aca_next = 128'(p00_reg) + (128'(p01_reg) << 32) + (128'(p02_reg) << 64);
        acb_next = (128'(p10_reg) << 32) + (128'(p11_reg) << 64) + (128'(p12_reg) << 96);
        k2a_next = 128'(k00_reg) + (128'(k11_reg) << 64);
        k2b_next = 128'(k01_reg) << 33;
    end

    // Stage 7: a*|c| and k*k.
    logic [127:0] ac_reg, k2_reg;
    zcsd_sb_t     sb7_reg;

    // Stage 8: miss test and discriminant.
    logic [127:0] q_next, q_reg;
    zcsd_sb_t     sb8_next, sb8_reg;

    always_comb
    begin
        sb8_next      = sb7_reg;
        sb8_next.kill = sb7_reg.kill || (!sb7_reg.cneg && (k2_reg < ac_reg));
        q_next        = sb7_reg.cneg ? (k2_reg + ac_reg) : (k2_reg - ac_reg);
    end

    // Valid bits travel with the data.
    logic [7:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_vld};
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            xmag_reg   <= xmag_next;
            ymag_reg   <= ymag_next;
            ux_reg     <= ux_next;
            uy_reg     <= uy_next;
            uxmag_reg  <= uxmag_next;
            uymag_reg  <= uymag_next;
            match1_reg <= (start_surface == cfg.surface_id);

            xx_reg     <= xmag_reg * xmag_reg;
            yy_reg     <= ymag_reg * ymag_reg;
            rr_reg     <= cfg.radius * cfg.radius;
            uxx_reg    <= uxmag_reg * uxmag_reg;
            uyy_reg    <= uymag_reg * uymag_reg;
            kx_reg     <= kx_full[63:0];
            ky_reg     <= ky_full[63:0];
            match2_reg <= match1_reg;

            c_reg      <= {2'b00, xx_reg} + {2'b00, yy_reg} - {4'b0000, rr_reg};
            a_reg      <= uxx_reg + uyy_reg;
            k_reg      <= kx_reg + ky_reg;
            match3_reg <= match2_reg;

            cmag_reg   <= cmag_next;
            sb4_reg    <= sb4_next;

            p00_reg    <= sb4_reg.a[31:0] * cmag_reg[31:0];
            p01_reg    <= sb4_reg.a[31:0] * cmag_reg[63:32];
            p02_reg    <= sb4_reg.a[31:0] * cmag_reg[65:64];
            p10_reg    <= sb4_reg.a[61:32] * cmag_reg[31:0];
            p11_reg    <= sb4_reg.a[61:32] * cmag_reg[63:32];
            p12_reg    <= sb4_reg.a[61:32] * cmag_reg[65:64];
            k00_reg    <= sb4_reg.kmag[31:0] * sb4_reg.kmag[31:0];
            k01_reg    <= sb4_reg.kmag[31:0] * sb4_reg.kmag[63:32];
            k11_reg    <= sb4_reg.kmag[63:32] * sb4_reg.kmag[63:32];
            sb5_reg    <= sb4_reg;

            aca_reg    <= aca_next;
            acb_reg    <= acb_next;
            k2a_reg    <= k2a_next;
            k2b_reg    <= k2b_next;
            sb6_reg    <= sb5_reg;

            ac_reg     <= aca_reg + acb_reg;
            k2_reg     <= k2a_reg + k2b_reg;
            sb7_reg    <= sb6_reg;

            q_reg      <= q_next;
            sb8_reg    <= sb8_next;
        end
    end

    assign out_vld = vld_reg[7];
    assign q       = q_reg;
    assign sb      = sb8_reg;

endmodule

`default_nettype wire

[rtl/zcsd_sqrt.sv]
// Pipelined integer square root of the 128-bit discriminant, one root bit per stage.
// Sixty-four register stages; depends on zcsd_pkg.
`default_nettype none

module zcsd_sqrt
    import zcsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_vld,
    input  wire logic [127:0] q,
    input  wire zcsd_sb_t     in_sb,
    output logic              out_vld,
    output logic [63:0]       root,
    output zcsd_sb_t          out_sb
);

    localparam int STEPS = 64;

    logic [127:0] rem_src [0:STEPS-1];
    logic [63:0]  res_src [0:STEPS-1];
    logic [127:0] rem_reg [0:STEPS-2];
    logic [63:0]  res_reg [0:STEPS-1];
    zcsd_sb_t     sb_reg  [0:STEPS-1];
    logic [STEPS-1:0] vld_reg;

    // First stage takes the discriminant with an empty root.
    assign rem_src[0] = q;
    assign res_src[0] = '0;

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            localparam int B = STEPS - 1 - i;
            logic [127:0] trial;
            logic         ge;

            if (i > 0)
            begin : g_link
                assign rem_src[i] = rem_reg[i-1];
                assign res_src[i] = res_reg[i-1];
            end

            // Try setting root bit B: subtract (2*res + 2^B) * 2^B when it fits.
            always_comb
            begin
                trial = (128'(res_src[i]) << (B + 1)) | (128'd1 << (2 * B));
                ge    = rem_src[i] >= trial;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    res_reg[i] <= ge ? (res_src[i] | (64'd1 << B)) : res_src[i];
                    sb_reg[i]  <= (i == 0) ? in_sb : sb_reg[(i == 0) ? 0 : i-1];
                end
            end

            if (i < STEPS - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[i] <= ge ? (rem_src[i] - trial) : rem_src[i];
                    end
                end
            end
        end
    endgenerate

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[STEPS-1];
    assign root    = res_reg[STEPS-1];
    assign out_sb  = sb_reg[STEPS-1];

endmodule

`default_nettype wire

[rtl/zcsd_div.sv]
// Root selection and pipelined restoring divide giving floor(num * 2^30 / a).
// Thirty-two register stages; depends on zcsd_pkg.
`default_nettype none

module zcsd_div
    import zcsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_vld,
    input  wire logic [63:0] root,
    input  wire zcsd_sb_t    in_sb,
    output logic             out_vld,
    output zcsd_res_t        res
);

    localparam int STEPS = 30;

    // Stage D0: pick the forward root and decide whether a distance exists.
    logic [64:0] num_next, num_reg;
    logic        go_next, go_reg, side0_reg;
    logic [61:0] a0_reg;

    always_comb
    begin
        num_next = '0;
        go_next  = 1'b0;
        if (in_sb.band || in_sb.cneg)
        begin
            if (in_sb.band && !in_sb.kneg)
            begin
                go_next = 1'b0;
            end
            else if (!in_sb.kneg)
            begin
                go_next  = 1'b1;
                num_next = (root >= in_sb.kmag) ? 65'(root - in_sb.kmag) : '0;
            end
            else
            begin
                go_next  = 1'b1;
                num_next = 65'(root) + 65'(in_sb.kmag);
            end
        end
        else if (in_sb.kneg)
        begin
            go_next  = 1'b1;
            num_next = (in_sb.kmag >= root) ? 65'(in_sb.kmag - root) : '0;
        end
        go_next = go_next && !in_sb.kill;
    end

    // Stage D1: range check and the integer quotient bit.
    logic        qb;
    logic [61:0] rem1_next;

    always_comb
    begin
        qb        = num_reg >= 65'(a0_reg);
        rem1_next = qb ? 62'(num_reg - 65'(a0_reg)) : num_reg[61:0];
    end

    logic [61:0] rem_reg  [0:STEPS-1];
    logic [61:0] a_reg    [0:STEPS-1];
    logic [30:0] q_reg    [0:STEPS];
    logic        fail_reg [0:STEPS];
    logic        side_reg [0:STEPS];
    logic [STEPS+1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            go_reg      <= go_next;
            side0_reg   <= in_sb.side;
            a0_reg      <= in_sb.a;

            rem_reg[0]  <= rem1_next;
            a_reg[0]    <= a0_reg;
            q_reg[0]    <= {30'd0, qb};
            fail_reg[0] <= !go_reg || (num_reg >= {2'b00, a0_reg, 1'b0});
            side_reg[0] <= side0_reg;
        end
    end

    // Fraction steps: shift the remainder and subtract a when it fits.
    genvar j;
    generate
        for (j = 0; j < STEPS; j++)
        begin : g_step
            logic [62:0] t;
            logic        ge;

            always_comb
            begin
                t  = {rem_reg[j], 1'b0};
                ge = t >= {1'b0, a_reg[j]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[j+1]    <= {q_reg[j][29:0], ge};
                    fail_reg[j+1] <= fail_reg[j];
                    side_reg[j+1] <= side_reg[j];
                end
            end

            if (j < STEPS - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j+1] <= ge ? 62'(t - {1'b0, a_reg[j]}) : t[61:0];
                        a_reg[j+1]   <= a_reg[j];
                    end
                end
            end
        end
    endgenerate

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], in_vld};
        end
    end

    always_comb
    begin
        res.side         = side_reg[STEPS];
        res.no_hit       = fail_reg[STEPS];
        res.hit_distance = fail_reg[STEPS] ? '0 : q_reg[STEPS];
    end

    assign out_vld = vld_reg[STEPS+1];

endmodule

`default_nettype wire

[rtl/zcylinder_side_and_distance.sv]
// One ray accepted every cycle while s_tready is high.
// Depth comes mostly from the 64-stage square root, one root bit per stage, and the 32-stage divide.
// The whole pipeline advances together; it holds only while the output skid register
// is full, and s_tready is the inverse of the skid register's valid bit.
// Reset (rst_n, asynchronous, active low) clears valid bits and loads the register defaults.
// Depends on zcsd_pkg, zcsd_front, zcsd_sqrt and zcsd_div.
`default_nettype none

module zcylinder_side_and_distance
    import zcsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input rays.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x[31:0], pos_y[63:32], dir_x[95:64], dir_y[127:96], start_surface[143:128]
    input  wire logic [143:0] s_tdata,
    // Results.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // side[0], hit_distance[31:1]
    output logic [31:0]       m_tdata,
    // no_hit[0]
    output logic              m_tuser,
    // Configuration writes.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    // Configuration registers.
    zcsd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x       <= RST_CENTER_X;
            cfg_reg.center_y       <= RST_CENTER_Y;
            cfg_reg.radius         <= RST_RADIUS;
            cfg_reg.surface_id     <= RST_SURF_ID;
            cfg_reg.coincident_tol <= RST_TOL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: cfg_reg.center_x       <= cfg_data;
                CFG_CENTER_Y: cfg_reg.center_y       <= cfg_data;
                CFG_RADIUS:   cfg_reg.radius         <= cfg_data[30:0];
                CFG_SURF_ID:  cfg_reg.surface_id     <= cfg_data[15:0];
                CFG_TOL:      cfg_reg.coincident_tol <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // Pipeline enable: everything advances unless the skid register is full.
    logic en;
    logic skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    logic         f_vld, r_vld, p_vld;
    logic [127:0] f_q;
    zcsd_sb_t     f_sb, r_sb;
    logic [63:0]  r_root;
    zcsd_res_t    p_res;

    zcsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_vld        (s_tvalid),
        .pos_x         (s_tdata[31:0]),
        .pos_y         (s_tdata[63:32]),
        .dir_x         (s_tdata[95:64]),
        .dir_y         (s_tdata[127:96]),
        .start_surface (s_tdata[143:128]),
        .cfg           (cfg_reg),
        .out_vld       (f_vld),
        .q             (f_q),
        .sb            (f_sb)
    );

    zcsd_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld),
        .q       (f_q),
        .in_sb   (f_sb),
        .out_vld (r_vld),
        .root    (r_root),
        .out_sb  (r_sb)
    );

    zcsd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (r_vld),
        .root    (r_root),
        .in_sb   (r_sb),
        .out_vld (p_vld),
        .res     (p_res)
    );

    // Output register with a skid stage behind it.
    logic      out_vld_reg, out_vld_next, skid_vld_next;
    zcsd_res_t out_reg, out_next, skid_reg, skid_next;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (!out_vld_reg || m_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = p_vld;
                out_next     = p_res;
            end
        end
        else if (p_vld && en)
        begin
            skid_vld_next = 1'b1;
            skid_next     = p_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.hit_distance, out_reg.side};
    assign m_tuser  = out_reg.no_hit;

endmodule

`default_nettype wire

[rtl/zcsd_checker.sv]
// Port-level checks for the z-cylinder side and distance block, with its bind.
// Sees only the top-level ports; depends on zcylinder_side_and_distance.
`default_nettype none

module zcsd_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [143:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata,
    input wire logic         m_tuser,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [2:0]   cfg_index,
    input wire logic [31:0]  cfg_data
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A result with no hit reports a zero distance.
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:1] == 31'd0)
        else $error("no_hit with nonzero distance");

    // Input back-pressure only appears while a result is waiting.
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // Input ready drops only after a result was refused.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input ready dropped without output stall");

endmodule

bind zcylinder_side_and_distance zcsd_checker u_zcsd_checker (.*);

`default_nettype wire

[tb/tb_zcylinder_side_and_distance.sv]
// Self-checking testbench for the z-cylinder side and distance block.
// Drives rays and register writes, predicts and checks each result; uses zcsd_pkg and the DUT.
`default_nettype none

module tb_zcylinder_side_and_distance;
    import zcsd_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  FLUSH_CYCLES = 130;
    localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic [15:0]        start_surface;
    } ray_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    // Shadow copy of the cylinder registers.
    logic signed [31:0] cyl_cx;
    logic signed [31:0] cyl_cy;
    logic [30:0]        cyl_radius;
    logic [15:0]        cyl_id;
    logic [30:0]        cyl_tol;

    zcsd_res_t pending_hits[$];
    int        err_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_hold_left;

    zcylinder_side_and_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Integer square root, rounded down.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= v)
            begin
                root = cand;
            end
        end
        return root;
    endfunction

    // Saturate a direction cosine to unit magnitude.
    function automatic longint sat_cosine(input logic signed [31:0] d);
        longint v;
        v = d;
        if (v > 64'sd1073741824)
        begin
            v = 64'sd1073741824;
        end
        if (v < -64'sd1073741824)
        begin
            v = -64'sd1073741824;
        end
        return v;
    endfunction

    // Side and nearest forward distance of one ray against the current cylinder.
    function automatic zcsd_res_t cylinder_hit(input ray_t r);
        longint             dx, dy, ux, uy;
        logic signed [127:0] xw, yw, uxw, uyw, rw, k, c;
        logic [127:0]       cmag, tolw, aw, ac, k2, q, numw, quo;
        logic [63:0]        kmag, s, num;
        logic               cneg, band, go, big, hit;
        zcsd_res_t          res;
        dx = longint'(r.pos_x) - longint'(cyl_cx);
        dy = longint'(r.pos_y) - longint'(cyl_cy);
        ux = sat_cosine(r.dir_x);
        uy = sat_cosine(r.dir_y);
        xw = dx;
        yw = dy;
        uxw = ux;
        uyw = uy;
        rw = {97'd0, cyl_radius};
        k = xw * uxw + yw * uyw;
        c = xw * xw + yw * yw - rw * rw;
        cneg = c < 0;
        cmag = cneg ? -c : c;
        tolw = 128'(cyl_tol) << FRAC_BITS;
        kmag = k < 0 ? 64'(-k) : 64'(k);
        aw = 128'(ux * ux) + 128'(uy * uy);
        go = 1'b0;
        big = 1'b0;
        hit = 1'b0;
        num = '0;
        res.side = (tolw < cmag) ? !cneg : (k > 0);
        res.hit_distance = '0;
        if (aw != 0 && r.start_surface != cyl_id)
        begin
            ac = aw * cmag;
            k2 = 128'(kmag) * 128'(kmag);
            if (cneg || k2 >= ac)
            begin
                q = cneg ? k2 + ac : k2 - ac;
                s = floor_sqrt(q);
                band = cmag < tolw;
                if (band || cneg)
                begin
                    if (band && k >= 0)
                    begin
                        go = 1'b0;
                    end
                    else if (k >= 0)
                    begin
                        num = s >= kmag ? s - kmag : '0;
                        go = 1'b1;
                    end
                    else
                    begin
                        if (128'(s) >= 2 * aw || 128'(kmag) >= 2 * aw)
                        begin
                            big = 1'b1;
                        end
                        else
                        begin
                            num = s + kmag;
                        end
                        go = 1'b1;
                    end
                end
                else if (k < 0)
                begin
                    num = kmag >= s ? kmag - s : '0;
                    go = 1'b1;
                end
                numw = num;
                if (go && !big && numw < 2 * aw)
                begin
                    quo = (numw << 30) / aw;
                    hit = 1'b1;
                    res.hit_distance = quo[30:0];
                end
            end
        end
        res.no_hit = !hit;
        return res;
    endfunction

    // Result checker and output back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        zcsd_res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_hits.size() == 0)
                begin
                    $error("Result transfer with no ray outstanding");
                    err_count++;
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (m_tdata[0] !== want.side)
                    begin
                        $error("side: expected %0d, got %0d", want.side, m_tdata[0]);
                        err_count++;
                    end
                    if (m_tdata[31:1] !== want.hit_distance)
                    begin
                        $error("hit_distance: expected %0d, got %0d",
                               want.hit_distance, m_tdata[31:1]);
                        err_count++;
                    end
                    if (m_tuser !== want.no_hit)
                    begin
                        $error("no_hit: expected %0d, got %0d", want.no_hit, m_tuser);
                        err_count++;
                    end
                end
            end
            if (recv_hold_left > 0)
            begin
                recv_hold_left <= recv_hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one ray and record its prediction once the transfer happens.
    task automatic send_ray(input ray_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.start_surface, r.dir_y, r.dir_x, r.pos_y, r.pos_x};
        forever
        begin
            @(posedge clk);
            if (s_tready)
            begin
                break;
            end
        end
        pending_hits.push_back(cylinder_hit(r));
    endtask

    // Stop offering rays and wait for the pipeline to empty.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    // One register write transfer, after which cfg_valid goes low; the shadow copy follows it.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
            begin
                break;
            end
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_CENTER_X: cyl_cx = val;
            CFG_CENTER_Y: cyl_cy = val;
            CFG_RADIUS:   cyl_radius = val[30:0];
            CFG_SURF_ID:  cyl_id = val[15:0];
            CFG_TOL:      cyl_tol = val[30:0];
            default:      ;
        endcase
    endtask

    task automatic load_cylinder(input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] rad, input logic [31:0] id,
                                 input logic [31:0] tol);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_SURF_ID, id);
        write_reg(CFG_TOL, tol);
    endtask

    function automatic ray_t mk_ray(input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] ux, input logic [31:0] uy,
                                    input logic [15:0] start);
        ray_t r;
        r.pos_x = px;
        r.pos_y = py;
        r.dir_x = ux;
        r.dir_y = uy;
        r.start_surface = start;
        return r;
    endfunction

    // Random ray: mostly placed near the cylinder, sometimes pure noise.
    function automatic ray_t random_ray();
        ray_t   r;
        longint span;
        int     pick;
        pick = $urandom_range(99);
        span = 3 * longint'(cyl_radius) + 4 * 65536;
        if (span > 64'd2147483647)
        begin
            span = 64'd2147483647;
        end
        if (pick < 12)
        begin
            r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            r.pos_x = 32'(longint'(cyl_cx) + longint'($urandom_range(2 * span)) - span);
            r.pos_y = 32'(longint'(cyl_cy) + longint'($urandom_range(2 * span)) - span);
            if (pick < 24)
            begin
                // Exactly on the surface, along one axis.
                r.pos_x = cyl_cx + $signed({1'b0, cyl_radius});
                r.pos_y = cyl_cy;
            end
            r.dir_x = $signed($urandom_range(2 * 1073741824)) - 32'sd1073741824;
            r.dir_y = $signed($urandom_range(2 * 1073741824)) - 32'sd1073741824;
            if (pick < 30)
            begin
                r.dir_x = '0;
            end
            else if (pick < 34)
            begin
                r.dir_y = '0;
            end
            else if (pick < 36)
            begin
                r.dir_x = '0;
                r.dir_y = '0;
            end
            r.start_surface = ($urandom_range(7) == 0) ? cyl_id : 16'($urandom);
        end
        return r;
    endfunction

    // Directed rays against the unit cylinder at the origin.
    task automatic test_directed();
        send_ray(mk_ray(32'd65536, 0, DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(32'd65536, 0, -DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(0, 0, DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(0, 0, 0, -DIR_ONE, 16'd1));
        send_ray(mk_ray(32'd196608, 0, -DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(32'd196608, 0, DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(0, 32'd196608, DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(32'd196608, 32'd65536, -DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(0, 0, 0, 0, 16'd1));
        send_ray(mk_ray(32'd196608, 0, -DIR_ONE, 0, 16'd0));
        send_ray(mk_ray(0, 0, 32'h7fffffff, 32'h80000000, 16'hffff));
        send_ray(mk_ray(32'h80000000, 0, 32'd1, 0, 16'd1));
        send_ray(mk_ray(32'h80000000, 0, DIR_ONE, 0, 16'd1));
        send_ray(mk_ray(32'h7fffffff, 32'h7fffffff, -DIR_ONE, -DIR_ONE, 16'd1));
        send_ray(mk_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'd2));
        send_ray(mk_ray(32'd65537, 0, 0, DIR_ONE, 16'd1));
        send_ray(mk_ray(32'd65535, 0, -32'sd759250125, 32'sd759250125, 16'd1));
        send_ray(mk_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff));
        drain_pipeline();
    endtask

    // Extreme register settings, plus writes to unused indexes.
    task automatic test_register_extremes();
        load_cylinder(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffff, 32'h7fffffff);
        write_reg(CFG_UNUSED_LO, 32'hdeadbeef);
        write_reg(CFG_UNUSED_HI, 32'h12345678);
        repeat (40) send_ray(random_ray());
        drain_pipeline();
        load_cylinder(32'h80000000, 32'h7fffffff, 0, 0, 0);
        repeat (40) send_ray(random_ray());
        drain_pipeline();
    endtask

    // Random rays over several cylinders for one idling pattern.
    task automatic test_random(input int sidle, input int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int n = 0; n < 6; n++)
        begin
            case (n)
                0: load_cylinder(0, 0, 32'd65536, 0, 1);
                1: load_cylinder($urandom, $urandom, $urandom_range(32'h00ffffff),
                                 $urandom, $urandom_range(32'hffff));
                2: load_cylinder(32'hfff00000, 32'h00100000, 32'd3276800, 7, 0);
                3: load_cylinder($urandom, $urandom, $urandom_range(32'h7fffffff),
                                 $urandom, $urandom_range(32'h7fffffff));
                4: load_cylinder(0, 0, 32'd16, 32'hffff, 32'd1000);
                default: load_cylinder($urandom, $urandom, $urandom_range(32'd655360),
                                       $urandom, $urandom_range(3));
            endcase
            repeat (80) send_ray(random_ray());
            drain_pipeline();
        end
    endtask

    // Long receiver hold-off so the pipeline fills and stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_cylinder(0, 0, 32'd131072, 32'd9, 32'd4);
        @(posedge clk);
        recv_hold_left <= 400;
        repeat (250) send_ray(random_ray());
        drain_pipeline();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_left = 0;
        cyl_cx = RST_CENTER_X;
        cyl_cy = RST_CENTER_Y;
        cyl_radius = RST_RADIUS;
        cyl_id = RST_SURF_ID;
        cyl_tol = RST_TOL;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random(18, 45);
        test_random(45, 18);
        test_random(0, 0);
        test_backpressure();

        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

[zcylinder_side_and_distance.f]
rtl/zcsd_pkg.sv
rtl/zcsd_front.sv
rtl/zcsd_sqrt.sv
rtl/zcsd_div.sv
rtl/zcylinder_side_and_distance.sv
rtl/zcsd_checker.sv
tb/tb_zcylinder_side_and_distance.sv
